/* rtl/md2_digest_engine_assert.svh */
// assertion macros shared by the md2 digest engine rtl
// no dependencies; included by the modules that carry checks
`ifndef MD2_DIGEST_ENGINE_ASSERT_SVH
`define MD2_DIGEST_ENGINE_ASSERT_SVH
`ifndef SYNTH
// property must hold at every edge outside reset
`define MD2_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("md2 assertion failed");
// condition must never be true outside reset
`define MD2_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("md2 forbidden condition seen");
`else
`define MD2_ASSERT(lbl, clk, rstn, prop)
`define MD2_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* rtl/md2_pkg.sv */
// shared types, sizes and the pi s-box table of the md2 digest engine
// no dependencies
package md2_pkg;

	localparam int BLOCK_BYTES = 16;
	localparam int STATE_BYTES = 48;
	localparam int ROUND_COUNT = 18;
	localparam int QUEUE_DEPTH = 4;

	localparam int FILL_W  = $clog2(BLOCK_BYTES);
	localparam int STEP_W  = $clog2(STATE_BYTES);
	localparam int ROUND_W = $clog2(ROUND_COUNT);

	// input item as it arrives on the push side
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_item_t;

	// result item on the pop side
	typedef struct packed {
		logic [63:0] digest_high;
		logic [63:0] digest_low;
	} out_item_t;

	// classified command between front and back
	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       is_end;
	} cmd_t;

	// md2 substitution table built from the digits of pi
	localparam logic [7:0] PI_SBOX [256] = '{
		8'h29,8'h2e,8'h43,8'hc9,8'ha2,8'hd8,8'h7c,8'h01,
		8'h3d,8'h36,8'h54,8'ha1,8'hec,8'hf0,8'h06,8'h13,
		8'h62,8'ha7,8'h05,8'hf3,8'hc0,8'hc7,8'h73,8'h8c,
		8'h98,8'h93,8'h2b,8'hd9,8'hbc,8'h4c,8'h82,8'hca,
		8'h1e,8'h9b,8'h57,8'h3c,8'hfd,8'hd4,8'he0,8'h16,
		8'h67,8'h42,8'h6f,8'h18,8'h8a,8'h17,8'he5,8'h12,
		8'hbe,8'h4e,8'hc4,8'hd6,8'hda,8'h9e,8'hde,8'h49,
		8'ha0,8'hfb,8'hf5,8'h8e,8'hbb,8'h2f,8'hee,8'h7a,
		8'ha9,8'h68,8'h79,8'h91,8'h15,8'hb2,8'h07,8'h3f,
		8'h94,8'hc2,8'h10,8'h89,8'h0b,8'h22,8'h5f,8'h21,
		8'h80,8'h7f,8'h5d,8'h9a,8'h5a,8'h90,8'h32,8'h27,
		8'h35,8'h3e,8'hcc,8'he7,8'hbf,8'hf7,8'h97,8'h03,
		8'hff,8'h19,8'h30,8'hb3,8'h48,8'ha5,8'hb5,8'hd1,
		8'hd7,8'h5e,8'h92,8'h2a,8'hac,8'h56,8'haa,8'hc6,
		8'h4f,8'hb8,8'h38,8'hd2,8'h96,8'ha4,8'h7d,8'hb6,
		8'h76,8'hfc,8'h6b,8'he2,8'h9c,8'h74,8'h04,8'hf1,
		8'h45,8'h9d,8'h70,8'h59,8'h64,8'h71,8'h87,8'h20,
		8'h86,8'h5b,8'hcf,8'h65,8'he6,8'h2d,8'ha8,8'h02,
		8'h1b,8'h60,8'h25,8'had,8'hae,8'hb0,8'hb9,8'hf6,
		8'h1c,8'h46,8'h61,8'h69,8'h34,8'h40,8'h7e,8'h0f,
		8'h55,8'h47,8'ha3,8'h23,8'hdd,8'h51,8'haf,8'h3a,
		8'hc3,8'h5c,8'hf9,8'hce,8'hba,8'hc5,8'hea,8'h26,
		8'h2c,8'h53,8'h0d,8'h6e,8'h85,8'h28,8'h84,8'h09,
		8'hd3,8'hdf,8'hcd,8'hf4,8'h41,8'h81,8'h4d,8'h52,
		8'h6a,8'hdc,8'h37,8'hc8,8'h6c,8'hc1,8'hab,8'hfa,
		8'h24,8'he1,8'h7b,8'h08,8'h0c,8'hbd,8'hb1,8'h4a,
		8'h78,8'h88,8'h95,8'h8b,8'he3,8'h63,8'he8,8'h6d,
		8'he9,8'hcb,8'hd5,8'hfe,8'h3b,8'h00,8'h1d,8'h39,
		8'hf2,8'hef,8'hb7,8'h0e,8'h66,8'h58,8'hd0,8'he4,
		8'ha6,8'h77,8'h72,8'hf8,8'heb,8'h75,8'h4b,8'h0a,
		8'h31,8'h44,8'h50,8'hb4,8'h8f,8'hed,8'h1f,8'h1a,
		8'hdb,8'h99,8'h8d,8'h33,8'h9f,8'h11,8'h83,8'h14
	};

endpackage

/* rtl/md2_front.sv */
// front end: accepts input items, drops empty ones, queues commands
// depends on md2_pkg and md2_digest_engine_assert.svh
`include "md2_digest_engine_assert.svh"
module md2_front #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  md2_pkg::in_item_t item,
	output logic             cmd_valid,
	output md2_pkg::cmd_t    cmd,
	input  logic             take
);
	import md2_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             accept;
	logic             keep;
	logic             wr_en;
	logic             rd_en;
	cmd_t             new_cmd;

	// classify: an item with neither byte nor end does nothing
	assign accept  = push && !full;
	assign keep    = item.byte_present || item.end_of_message;
	assign wr_en   = accept && keep;
	assign rd_en   = take && cmd_valid;
	assign new_cmd = '{data: item.data_byte, has_byte: item.byte_present,
		is_end: item.end_of_message};

	assign full      = (count_q == CNT_W'(DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = slot_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= new_cmd;
		end
	end

	// queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// occupancy checks
	`MD2_NEVER(a_count_bound, clk, arst_n, count_q > CNT_W'(DEPTH))
	`MD2_ASSERT(a_count_up, clk, arst_n, (wr_en && !rd_en) |=> (count_q == $past(count_q) + 1'b1))
	`MD2_ASSERT(a_count_down, clk, arst_n, (rd_en && !wr_en) |=> (count_q == $past(count_q) - 1'b1))
endmodule

/* rtl/md2_core.sv */
// back end: checksum update, block compression, padding and digest output
// depends on md2_pkg and md2_digest_engine_assert.svh
`include "md2_digest_engine_assert.svh"
module md2_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  md2_pkg::cmd_t     cmd,
	output logic              take,
	output logic              empty,
	input  logic              pop,
	output md2_pkg::out_item_t result
);
	import md2_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_LOAD,
		S_ROUND,
		S_OUT
	} state_t;

	// where to go once a compression finishes
	typedef enum logic [1:0] {
		A_IDLE,
		A_PAD,
		A_CSUM,
		A_OUT
	} after_t;

	state_t                          state_q;
	after_t                          after_q;
	logic                            src_csum_q;
	logic [STATE_BYTES-1:0][7:0]     hash_q;
	logic [BLOCK_BYTES-1:0][7:0]     csum_q;
	logic [BLOCK_BYTES-1:0][7:0]     buf_q;
	logic [7:0]                      last_q;
	logic [FILL_W-1:0]               fill_q;
	logic [7:0]                      pad_q;
	logic [7:0]                      t_q;
	logic [STEP_W-1:0]               step_q;
	logic [ROUND_W-1:0]              round_q;
	logic                            out_valid_q;
	out_item_t                       out_q;

	logic                            absorb_en;
	logic [7:0]                      absorb_byte;
	logic [7:0]                      csum_new;
	logic                            wrap;
	logic [FILL_W-1:0]               fill_nxt;
	logic [7:0]                      pad_val;
	logic [7:0]                      step_byte;
	logic [BLOCK_BYTES-1:0][7:0]     blk;
	out_item_t                       digest;

	assign take = (state_q == S_IDLE) && cmd_valid;

	// byte absorb path: checksum through the s-box, buffer fill
	always_comb begin
		absorb_en   = 1'b0;
		absorb_byte = pad_q;
		case (state_q)
			S_IDLE: begin
				absorb_en   = take && cmd.has_byte;
				absorb_byte = cmd.data;
			end
			S_PAD: begin
				absorb_en   = 1'b1;
				absorb_byte = pad_q;
			end
			default: begin
				absorb_en = 1'b0;
			end
		endcase
	end

	assign csum_new = csum_q[fill_q] ^ PI_SBOX[absorb_byte ^ last_q];
	assign wrap     = (fill_q == FILL_W'(BLOCK_BYTES - 1));
	assign fill_nxt = absorb_en ? (wrap ? '0 : fill_q + 1'b1) : fill_q;
	// padding length seen after the optional final byte: 1 to 16
	assign pad_val  = 8'(BLOCK_BYTES) - {{(8 - FILL_W){1'b0}}, fill_nxt};

	// one s-box step on the byte at the head of the rotating state
	assign step_byte = hash_q[0] ^ PI_SBOX[t_q];
	assign blk       = src_csum_q ? csum_q : buf_q;

	// digest from the first sixteen state bytes
	always_comb begin
		digest = '0;
		for (int i = 0; i < 8; i++) begin
			digest.digest_high[63 - 8 * i -: 8] = hash_q[i];
			digest.digest_low[63 - 8 * i -: 8]  = hash_q[8 + i];
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

	// message buffer
	always_ff @(posedge clk) begin
		if (absorb_en) begin
			buf_q[fill_q] <= absorb_byte;
		end
	end

	// sequencer with hash, checksum and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			after_q     <= A_IDLE;
			src_csum_q  <= 1'b0;
			hash_q      <= '0;
			csum_q      <= '0;
			last_q      <= '0;
			fill_q      <= '0;
			pad_q       <= '0;
			t_q         <= '0;
			step_q      <= '0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			if (absorb_en) begin
				csum_q[fill_q] <= csum_new;
				last_q         <= csum_new;
				fill_q         <= fill_nxt;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						pad_q <= pad_val;
						if (cmd.has_byte && wrap) begin
							state_q    <= S_LOAD;
							src_csum_q <= 1'b0;
							after_q    <= cmd.is_end ? A_PAD : A_IDLE;
						end else if (cmd.is_end) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					if (wrap) begin
						state_q    <= S_LOAD;
						src_csum_q <= 1'b0;
						after_q    <= A_CSUM;
					end
				end
				S_LOAD: begin
					for (int j = 0; j < BLOCK_BYTES; j++) begin
						hash_q[BLOCK_BYTES + j]     <= blk[j];
						hash_q[2 * BLOCK_BYTES + j] <= blk[j] ^ hash_q[j];
					end
					t_q     <= '0;
					step_q  <= '0;
					round_q <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					for (int k = 0; k < STATE_BYTES - 1; k++) begin
						hash_q[k] <= hash_q[k + 1];
					end
					hash_q[STATE_BYTES - 1] <= step_byte;
					if (step_q == STEP_W'(STATE_BYTES - 1)) begin
						step_q <= '0;
						t_q    <= step_byte + {{(8 - ROUND_W){1'b0}}, round_q};
						if (round_q == ROUND_W'(ROUND_COUNT - 1)) begin
							case (after_q)
								A_IDLE: state_q <= S_IDLE;
								A_PAD:  state_q <= S_PAD;
								A_CSUM: begin
									state_q    <= S_LOAD;
									src_csum_q <= 1'b1;
									after_q    <= A_OUT;
								end
								A_OUT:  state_q <= S_OUT;
								default: state_q <= S_IDLE;
							endcase
						end else begin
							round_q <= round_q + 1'b1;
						end
					end else begin
						step_q <= step_q + 1'b1;
						t_q    <= step_byte;
					end
				end
				S_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_q       <= digest;
						hash_q      <= '0;
						csum_q      <= '0;
						last_q      <= '0;
						fill_q      <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// sequencer checks
	`MD2_NEVER(a_take_busy, clk, arst_n, take && (state_q != S_IDLE))
	`MD2_ASSERT(a_out_write, clk, arst_n, (state_q == S_OUT && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE && fill_q == '0))
	`MD2_ASSERT(a_out_hold, clk, arst_n, (out_valid_q && !pop) |=> (out_valid_q && $stable(out_q)))
	`MD2_NEVER(a_round_bound, clk, arst_n, round_q > ROUND_W'(ROUND_COUNT - 1))
endmodule

/* rtl/md2_digest_engine.sv */
// MD2 digest engine, at most one message byte per input item, 128-bit digest per message.
// A message byte updates the checksum and fills the buffer in the back end; every
// completed 16-byte block then takes one load and 18 rounds of 48 S-box steps,
// one lookup per cycle on a rotating 48-byte state. An end item adds 1 to 16
// padding bytes, the padding-block and checksum-block compressions and the
// posting of the digest. A four-entry command queue lets input transfers
// continue while a block compresses; the digest waits in an output register
// until popped. The hash, checksum and fill state clear after each digest,
// so the next byte begins a new message.
// depends on md2_pkg, md2_front and md2_core
module md2_digest_engine #(
	parameter int QUEUE_DEPTH = md2_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  md2_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output md2_pkg::out_item_t result
);
	import md2_pkg::*;

	logic cmd_valid;
	logic take;
	cmd_t cmd;

	// front: accept and classify, command queue
	md2_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.take     (take)
	);

	// back: checksum, compression, padding, digest
	md2_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.take     (take),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);
endmodule

/* tb/sv/md2_digest_engine_test.sv */
// self-checking testbench for md2_digest_engine: directed table, then random messages
// digests from the hand-entered table or a local md2 model; depends on md2_pkg and md2_digest_engine
module md2_digest_engine_test;
	import md2_pkg::*;

	localparam int CYCLE_LIMIT = 20000000;
	localparam int ITEM_TARGET = 1800;
	localparam int TAIL_CYCLES = 64;

	// stimulus row: input item plus a hand-entered digest where one is known
	typedef struct packed {
		in_item_t  item;
		logic      typed;
		out_item_t digest;
	} stim_row_t;

	typedef enum logic [1:0] {POP_ALWAYS, POP_HALF, POP_RARE} pop_mode_e;

	// directed rows: empty message, "a", "abc" with an ignored item inside,
	// one full block of extreme bytes closed by an end-only item, byte with end
	localparam stim_row_t DIRECTED [24] = '{
		'{{8'h00, 1'b0, 1'b1}, 1'b1, 128'h8350e5a3e24c153df2275c9f80692773},
		'{{8'h61, 1'b1, 1'b1}, 1'b1, 128'h32ec01ec4a6dac72c0ab96fb34c0b5d1},
		'{{8'h61, 1'b1, 1'b0}, 1'b0, 128'h0},
		'{{8'hff, 1'b0, 1'b0}, 1'b0, 128'h0},
		'{{8'h62, 1'b1, 1'b0}, 1'b0, 128'h0},
		'{{8'h63, 1'b1, 1'b1}, 1'b1, 128'hda853b0d3f88d99b30283a69e6ded6bb},
		'{{8'hff, 1'b1, 1'b0}, 1'b0, 128'h0},
		'{{8'h00, 1'b1, 1'b0}, 1'b0, 128'h0},
		'{{8'h80, 1'b1, 1'b0}, 1'b0, 128'h0},
		'{{8'h01, 1'b1, 1'b0}, 1'b0, 128'h0},
		'{{8'h7f, 1'b1, 1'b0}, 1'b0, 128'h0},
		'{{8'hfe, 1'b1, 1'b0}, 1'b0, 128'h0},
		'{{8'h55, 1'b1, 1'b0}, 1'b0, 128'h0},
		'{{8'haa, 1'b1, 1'b0}, 1'b0, 128'h0},
		'{{8'h00, 1'b1, 1'b0}, 1'b0, 128'h0},
		'{{8'hff, 1'b1, 1'b0}, 1'b0, 128'h0},
		'{{8'h0f, 1'b1, 1'b0}, 1'b0, 128'h0},
		'{{8'hf0, 1'b1, 1'b0}, 1'b0, 128'h0},
		'{{8'h3c, 1'b1, 1'b0}, 1'b0, 128'h0},
		'{{8'hc3, 1'b1, 1'b0}, 1'b0, 128'h0},
		'{{8'h29, 1'b1, 1'b0}, 1'b0, 128'h0},
		'{{8'h14, 1'b1, 1'b0}, 1'b0, 128'h0},
		'{{8'hff, 1'b0, 1'b1}, 1'b0, 128'h0},
		'{{8'hff, 1'b1, 1'b1}, 1'b0, 128'h0}
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_item_t  item = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_item_t result;

	// local copy of the digest state
	logic [7:0] mix_state [STATE_BYTES];
	logic [7:0] sum_bytes [BLOCK_BYTES];
	logic [7:0] sum_last;
	logic [7:0] msg_block [BLOCK_BYTES];
	int         fill_count;

	out_item_t  digest_q [$];
	int         fail_count = 0;
	int         item_count = 0;
	int         message_count = 0;
	int         digest_count = 0;
	int         cycle_count = 0;
	int         burst_left = 0;
	int         pop_cycle = 0;
	pop_mode_e  pop_mode = POP_ALWAYS;

	md2_digest_engine DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// 18 rounds over the 48-byte state after loading a block
	function automatic void compress_model(input logic [7:0] blk [BLOCK_BYTES]);
		logic [7:0] t;
		t = 8'h00;
		for (int j = 0; j < BLOCK_BYTES; j++) begin
			mix_state[BLOCK_BYTES + j] = blk[j];
			mix_state[2 * BLOCK_BYTES + j] = blk[j] ^ mix_state[j];
		end
		for (int r = 0; r < ROUND_COUNT; r++) begin
			for (int k = 0; k < STATE_BYTES; k++) begin
				mix_state[k] = mix_state[k] ^ PI_SBOX[t];
				t = mix_state[k];
			end
			t = t + 8'(r);
		end
	endfunction

	// checksum update and block fill for one byte
	function automatic void absorb_model(input logic [7:0] b);
		logic [7:0] c;
		c = sum_bytes[fill_count] ^ PI_SBOX[b ^ sum_last];
		sum_bytes[fill_count] = c;
		sum_last = c;
		msg_block[fill_count] = b;
		fill_count++;
		if (fill_count == BLOCK_BYTES) begin
			compress_model(msg_block);
			fill_count = 0;
		end
	endfunction

	function automatic void clear_model();
		foreach (mix_state[i]) mix_state[i] = 8'h00;
		foreach (sum_bytes[i]) begin
			sum_bytes[i] = 8'h00;
			msg_block[i] = 8'h00;
		end
		sum_last = 8'h00;
		fill_count = 0;
	endfunction

	// advance the model by one item; returns 1 with the digest on an end item
	function automatic bit predict_digest(input in_item_t it, output out_item_t d);
		int pad;
		d = '0;
		if (it.byte_present)
			absorb_model(it.data_byte);
		if (!it.end_of_message)
			return 1'b0;
		pad = BLOCK_BYTES - fill_count;
		repeat (pad) absorb_model(8'(pad));
		compress_model(sum_bytes);
		for (int i = 0; i < 8; i++) begin
			d.digest_high = {d.digest_high[55:0], mix_state[i]};
			d.digest_low = {d.digest_low[55:0], mix_state[8 + i]};
		end
		clear_model();
		return 1'b1;
	endfunction

	// one transfer on the push side, with bursts and random gaps
	task automatic send_row(input stim_row_t r);
		int gap;
		out_item_t d;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		item <= r.item;
		do @(posedge clk); while (full);
		if (r.item.byte_present || r.item.end_of_message)
			item_count++;
		if (predict_digest(r.item, d)) begin
			digest_q.push_back(r.typed ? r.digest : d);
			message_count++;
		end
		@(negedge clk);
	endtask

	// receiver stall pattern in a randomly chosen mode: pop always, about half the time, or rarely
	always @(negedge clk) begin
		pop_cycle <= pop_cycle + 1;
		if (pop_cycle % 256 == 0)
			pop_mode <= pop_mode_e'($urandom_range(0, 2));
		case (pop_mode)
			POP_ALWAYS: pop <= 1'b1;
			POP_HALF:   pop <= 1'($urandom_range(0, 1));
			default:    pop <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// compare each popped digest with the oldest expected one
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (digest_q.size() == 0) begin
				$error("digest transfer with nothing expected: %h", result);
				fail_count++;
			end else begin
				want = digest_q.pop_front();
				digest_count++;
				if (result.digest_high !== want.digest_high) begin
					$error("digest_high expected %h actual %h",
						want.digest_high, result.digest_high);
					fail_count++;
				end
				if (result.digest_low !== want.digest_low) begin
					$error("digest_low expected %h actual %h",
						want.digest_low, result.digest_low);
					fail_count++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d digests pending",
				cycle_count, digest_q.size());
			$display("md2_digest_engine_test NOT OK");
			$finish;
		end
	end

	initial begin
		stim_row_t r;
		int        len;
		bit        end_on_byte;
		clear_model();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (DIRECTED[i])
			send_row(DIRECTED[i]);

		// random messages: mostly short, some exact block multiples, some long
		r.typed = 1'b0;
		r.digest = '0;
		while (item_count < ITEM_TARGET) begin
			case ($urandom_range(0, 6))
				0, 1, 2, 3: len = $urandom_range(0, 20);
				4:          len = BLOCK_BYTES * $urandom_range(1, 3);
				default:    len = $urandom_range(21, 70);
			endcase
			end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
			for (int i = 0; i < len; i++) begin
				// occasional item with neither byte nor end
				if ($urandom_range(0, 11) == 0) begin
					r.item = {8'($urandom), 1'b0, 1'b0};
					send_row(r);
				end
				r.item = {8'($urandom), 1'b1, end_on_byte && (i == len - 1)};
				send_row(r);
			end
			if (!end_on_byte) begin
				r.item = {8'($urandom), 1'b0, 1'b1};
				send_row(r);
			end
		end
		push <= 1'b0;

		// drain, then let the engine settle
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d items over %0d messages, %0d digests checked",
			item_count, message_count, digest_count);
		if (fail_count == 0)
			$display("md2_digest_engine_test OK");
		else
			$display("md2_digest_engine_test NOT OK");
		$finish;
	end

endmodule

/* md2_digest_engine.f */
+incdir+rtl
rtl/md2_pkg.sv
rtl/md2_front.sv
rtl/md2_core.sv
rtl/md2_digest_engine.sv
tb/sv/md2_digest_engine_test.sv
